[src/bmp_stream_decoder_core_assert.svh]
// Assertion macros for the checker file of the decoder.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef BMP_STREAM_DECODER_CORE_ASSERT_SVH
`define BMP_STREAM_DECODER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define BSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define BSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/bsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder package
// Shared types, result codes and header layout constants.
// ----------------------------------------------------------------------------
package bsd_pkg;

    // Header layout
    localparam int unsigned HDR_BYTES      = 34;
    localparam int unsigned HDR_INFO_BASE  = 14;
    localparam int unsigned POS_SIG_B      = 0;
    localparam int unsigned POS_SIG_M      = 1;
    localparam int unsigned POS_OFFSET     = 10;
    localparam int unsigned POS_INFO       = 14;
    localparam int unsigned POS_WIDTH      = 18;
    localparam int unsigned POS_HEIGHT     = 22;
    localparam int unsigned POS_DEPTH      = 28;
    localparam int unsigned POS_COMPR      = 30;
    localparam int unsigned INFO_COMPR_MIN = 20;

    localparam logic [7:0]  SIG_B          = 8'h42;
    localparam logic [7:0]  SIG_M          = 8'h4D;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
    localparam logic [15:0] DEPTH_24       = 16'd24;
    localparam logic [15:0] DEPTH_32       = 16'd32;
    localparam logic [31:0] COMPR_RGB      = 32'd0;
    localparam logic [31:0] COMPR_BITFIELD = 32'd3;

    localparam int unsigned FIFO_DEPTH     = 4;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PIXEL  = 2'd0;
    localparam t_kind KIND_ACCEPT = 2'd1;
    localparam t_kind KIND_REJECT = 2'd2;

    typedef logic [2:0] t_err;
    localparam t_err ERR_NONE   = 3'd0;
    localparam t_err ERR_SHORT  = 3'd0;
    localparam t_err ERR_SIG    = 3'd1;
    localparam t_err ERR_OFFSET = 3'd2;
    localparam t_err ERR_INFO   = 3'd3;
    localparam t_err ERR_DIMS   = 3'd4;
    localparam t_err ERR_DEPTH  = 3'd5;
    localparam t_err ERR_COMPR  = 3'd6;

    // One file byte as classified by the front end
    typedef struct packed {
        logic [7:0]  byte_value;
        logic        start;
        logic [31:0] file_size;
        logic [31:0] pos;
    } t_tok;

    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [31:0] pixel_argb;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last_pixel;
    } t_res;

endpackage

[src/bsd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder input channel
// Valid/ready channel carrying one file byte per transfer.
// ----------------------------------------------------------------------------
interface bsd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        start_of_file;
    logic [31:0] file_size;

    modport source (output valid, output byte_value, output start_of_file,
                    output file_size, input ready);
    modport sink   (input valid, input byte_value, input start_of_file,
                    input file_size, output ready);
endinterface

[src/bsd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder result channel
// Valid/ready channel carrying one header verdict or pixel per transfer.
// ----------------------------------------------------------------------------
interface bsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [31:0] pixel_argb;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_pixel;

    modport source (output valid, output kind, output error_code, output pixel_argb,
                    output pixel_row, output pixel_col, output image_width,
                    output image_height, output last_pixel, input ready);
    modport sink   (input valid, input kind, input error_code, input pixel_argb,
                    input pixel_row, input pixel_col, input image_width,
                    input image_height, input last_pixel, output ready);
endinterface

[src/bsd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder token queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module bsd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsd_pkg::t_tok i_tok,
    input  logic          i_pop,
    output bsd_pkg::t_tok o_tok,
    output logic          o_full,
    output logic          o_empty
);
    import bsd_pkg::*;

    localparam int unsigned AW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

    t_tok          r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_tok;
                r_wr        <= (r_wr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

[src/bsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder front end
// Accepts file bytes, numbers them within the file and drops stray bytes.
// ----------------------------------------------------------------------------
module bsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsd_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output bsd_pkg::t_tok o_tok
);
    import bsd_pkg::*;

    logic        r_seen;
    logic [31:0] r_pos;
    logic        accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Bytes that arrive before any start of file carry no meaning.
    assign o_push           = accept && (i_in.start_of_file || r_seen);
    assign o_tok.byte_value = i_in.byte_value;
    assign o_tok.start      = i_in.start_of_file;
    assign o_tok.file_size  = i_in.file_size;
    assign o_tok.pos        = i_in.start_of_file ? '0 : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_pos  <= '0;
        end else if (accept) begin
            if (i_in.start_of_file) begin
                r_seen <= 1'b1;
                r_pos  <= 32'd1;
            end else if (r_seen) begin
                r_pos <= r_pos + 32'd1;
            end
        end
    end
endmodule

[src/bsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder back end
// Captures header fields, checks them, packs pixels and holds the result.
// ----------------------------------------------------------------------------
module bsd_back #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  bsd_pkg::t_tok i_tok,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output bsd_pkg::t_res o_res
);
    import bsd_pkg::*;

    localparam int unsigned WW   = $clog2(MAX_DIM + 1);
    localparam int unsigned SW   = WW + 3;
    localparam int unsigned PW   = SW + WW;
    localparam int unsigned SUMW = ((PW > 32) ? PW : 32) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_HEADER, S_CHK_MUL, S_CHK_CMP, S_SKIP, S_PIXELS, S_DONE
    } t_state;

    t_state        r_state;
    logic          r_valid;
    t_res          r_res;

    logic [31:0]   r_size, r_offset, r_info, r_width, r_height, r_compr;
    logic [15:0]   r_depth;
    logic          r_sig_ok;

    logic          r_pre_bad;
    t_err          r_pre_err;
    logic [PW-1:0] r_prod;
    logic [SW-1:0] r_stride, r_rowbytes;
    logic [WW-1:0] r_hmag, r_wlast;
    logic          r_bottom_up, r_bpx4;

    logic [SW-1:0] r_bi;
    logic [1:0]    r_k;
    logic [WW-1:0] r_col, r_row;
    logic [7:0]    r_blue, r_green, r_red;

    // Combinational terms
    logic          out_free, busy_chk, hdr_pop, do_px;
    logic [7:0]    b;
    logic [1:0]    lane;
    logic [5:0]    p6;
    logic [31:0]   h_mag32, compr_eff;
    logic          w_bad, h_bad, bpx4;
    logic          pre_bad;
    t_err          pre_err;
    logic [WW-1:0] w_n;
    logic [SW-1:0] wbytes, stride;
    logic [SUMW-1:0] total;
    logic          trunc;
    logic          in_data, k_end, px_last, row_end;
    logic [SW-1:0] bi_inc;
    logic [WW-1:0] row_out;
    t_res          res_short, res_chk, res_px;

    assign out_free = !r_valid || i_ready;
    assign busy_chk = (r_state == S_CHK_MUL) || (r_state == S_CHK_CMP);
    assign o_pop    = !i_empty && out_free && !busy_chk;
    assign b        = i_tok.byte_value;
    assign p6       = i_tok.pos[5:0];
    // Every four-byte field starts on a position that is 2 modulo 4.
    assign lane     = p6[1:0] - 2'd2;
    assign hdr_pop  = o_pop && !i_tok.start && (r_state == S_HEADER);
    assign do_px    = o_pop && !i_tok.start &&
                      (((r_state == S_SKIP) && (i_tok.pos == r_offset)) ||
                       (r_state == S_PIXELS));

    // Header checks, in file order
    always_comb begin
        h_mag32   = r_height[31] ? (~r_height + 32'd1) : r_height;
        w_bad     = r_width[31] || (r_width == '0) || (r_width > 32'(MAX_DIM));
        h_bad     = (r_height == '0) || (h_mag32 > 32'(MAX_DIM));
        bpx4      = (r_depth == DEPTH_32);
        compr_eff = (r_info >= 32'(INFO_COMPR_MIN)) ? r_compr : COMPR_RGB;
        pre_bad   = 1'b1;
        if (!r_sig_ok) begin
            pre_err = ERR_SIG;
        end else if ((r_offset >= r_size) || (r_offset < 32'(HDR_BYTES))) begin
            pre_err = ERR_OFFSET;
        end else if (({1'b0, r_info} + 33'(HDR_INFO_BASE)) > {1'b0, r_size}) begin
            pre_err = ERR_INFO;
        end else if (w_bad || h_bad) begin
            pre_err = ERR_DIMS;
        end else if ((r_depth != DEPTH_24) && (r_depth != DEPTH_32)) begin
            pre_err = ERR_DEPTH;
        end else if ((compr_eff != COMPR_RGB) && (compr_eff != COMPR_BITFIELD)) begin
            pre_err = ERR_COMPR;
        end else begin
            pre_err = ERR_NONE;
            pre_bad = 1'b0;
        end
        w_n    = r_width[WW-1:0];
        wbytes = bpx4 ? (SW'(w_n) << 2) : (SW'(w_n) + (SW'(w_n) << 1));
        stride = (wbytes + SW'(3)) & ~SW'(3);
        total  = SUMW'(r_offset) + SUMW'(r_prod);
        trunc  = total > SUMW'(r_size);
    end

    // Pixel path
    always_comb begin
        in_data = r_bi < r_rowbytes;
        k_end   = r_bpx4 ? (r_k == 2'd3) : (r_k == 2'd2);
        px_last = (r_row == r_hmag - 1'b1) && (r_col == r_wlast);
        bi_inc  = r_bi + 1'b1;
        row_end = (bi_inc == r_stride);
        row_out = r_bottom_up ? (r_hmag - 1'b1 - r_row) : r_row;
    end

    always_comb begin
        res_short            = '0;
        res_short.kind       = KIND_REJECT;
        res_short.error_code = ERR_SHORT;

        res_chk = '0;
        if (r_pre_bad) begin
            res_chk.kind       = KIND_REJECT;
            res_chk.error_code = r_pre_err;
        end else if (trunc) begin
            res_chk.kind       = KIND_REJECT;
            res_chk.error_code = ERR_COMPR;
        end else begin
            res_chk.kind         = KIND_ACCEPT;
            res_chk.image_width  = 13'(r_width);
            res_chk.image_height = 13'(r_hmag);
        end

        res_px            = '0;
        res_px.kind       = KIND_PIXEL;
        res_px.pixel_argb = {r_bpx4 ? b : ALPHA_OPAQUE, r_bpx4 ? r_red : b,
                             r_green, r_blue};
        res_px.pixel_row  = 12'(row_out);
        res_px.pixel_col  = 12'(r_col);
        res_px.last_pixel = px_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_valid <= 1'b0;
            end

            if (o_pop && i_tok.start) begin
                r_size <= i_tok.file_size;
                if (i_tok.file_size < 32'(HDR_BYTES)) begin
                    r_res   <= res_short;
                    r_valid <= 1'b1;
                    r_state <= S_DONE;
                end else begin
                    r_sig_ok <= (b == SIG_B);
                    r_state  <= S_HEADER;
                end
            end

            if (hdr_pop) begin
                if (p6 == 6'(POS_SIG_M)) begin
                    r_sig_ok <= r_sig_ok & (b == SIG_M);
                end else if (p6 >= 6'(POS_OFFSET) && p6 < 6'(POS_INFO)) begin
                    r_offset[8*lane +: 8] <= b;
                end else if (p6 >= 6'(POS_INFO) && p6 < 6'(POS_WIDTH)) begin
                    r_info[8*lane +: 8] <= b;
                end else if (p6 >= 6'(POS_WIDTH) && p6 < 6'(POS_HEIGHT)) begin
                    r_width[8*lane +: 8] <= b;
                end else if (p6 >= 6'(POS_HEIGHT) && p6 < 6'(POS_HEIGHT + 4)) begin
                    r_height[8*lane +: 8] <= b;
                end else if (p6 >= 6'(POS_DEPTH) && p6 < 6'(POS_COMPR)) begin
                    r_depth[8*p6[0] +: 8] <= b;
                end else if (p6 >= 6'(POS_COMPR) && p6 < 6'(HDR_BYTES)) begin
                    r_compr[8*lane +: 8] <= b;
                end
                if (i_tok.pos == 32'(HDR_BYTES - 1)) begin
                    r_state <= S_CHK_MUL;
                end
            end

            // The size product is registered before the truncation compare.
            if (r_state == S_CHK_MUL) begin
                r_pre_bad   <= pre_bad;
                r_pre_err   <= pre_err;
                r_prod      <= PW'(stride) * PW'(h_mag32[WW-1:0]);
                r_stride    <= stride;
                r_rowbytes  <= wbytes;
                r_hmag      <= h_mag32[WW-1:0];
                r_wlast     <= w_n - 1'b1;
                r_bottom_up <= !r_height[31];
                r_bpx4      <= bpx4;
                r_bi        <= '0;
                r_k         <= '0;
                r_col       <= '0;
                r_row       <= '0;
                r_state     <= S_CHK_CMP;
            end

            if (r_state == S_CHK_CMP && out_free) begin
                r_res   <= res_chk;
                r_valid <= 1'b1;
                r_state <= (r_pre_bad || trunc) ? S_DONE : S_SKIP;
            end

            if (do_px) begin
                r_state <= S_PIXELS;
                if (in_data) begin
                    case (r_k)
                        2'd0:    r_blue  <= b;
                        2'd1:    r_green <= b;
                        2'd2:    r_red   <= b;
                        default: r_red   <= r_red;
                    endcase
                    if (k_end) begin
                        r_k     <= '0;
                        r_col   <= r_col + 1'b1;
                        r_res   <= res_px;
                        r_valid <= 1'b1;
                        if (px_last) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                if (row_end) begin
                    r_bi  <= '0;
                    r_k   <= '0;
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_bi <= bi_inc;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

[src/bmp_stream_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder core
// Parses a 24-bit or 32-bit uncompressed BMP byte stream into header verdict
// and ARGB pixel results.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on i_in while its queue has room
// and gives at most one result per byte on o_out. A front end numbers the
// bytes of each file and writes them into a four-entry queue; the back end
// takes one byte a cycle from the queue while its output register is free,
// captures the header, packs pixels and holds each result in that register,
// so no byte is taken while a result waits, nor during the header check
// after byte 33 (the row stride times height product, then the compare
// against the file size, which waits for a free output register); the queue
// takes bytes that arrive meanwhile. Each byte is written to the queue before
// the back end registers its result. MAX_DIM sets the largest accepted width
// and height and the widths of the row, column and stride counters.
module bmp_stream_decoder_core #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bsd_in_if.sink   i_in,
    bsd_out_if.source o_out
);
    import bsd_pkg::*;

    logic push, pop, full, empty, res_valid;
    t_tok tok_in, tok_out;
    t_res res;

    bsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_tok   (tok_in)
    );

    bsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (tok_in),
        .i_pop   (pop),
        .o_tok   (tok_out),
        .o_full  (full),
        .o_empty (empty)
    );

    bsd_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_tok   (tok_out),
        .o_pop   (pop),
        .o_valid (res_valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.valid        = res_valid;
    assign o_out.kind         = res.kind;
    assign o_out.error_code   = res.error_code;
    assign o_out.pixel_argb   = res.pixel_argb;
    assign o_out.pixel_row    = res.pixel_row;
    assign o_out.pixel_col    = res.pixel_col;
    assign o_out.image_width  = res.image_width;
    assign o_out.image_height = res.image_height;
    assign o_out.last_pixel   = res.last_pixel;
endmodule

[src/bsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream decoder port checker
// Watches the result channel for malformed or unstable results.
// ----------------------------------------------------------------------------
`include "bmp_stream_decoder_core_assert.svh"

module bsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [2:0]  i_error_code,
    input logic [31:0] i_pixel_argb,
    input logic [12:0] i_image_width,
    input logic [12:0] i_image_height,
    input logic        i_last_pixel
);
    import bsd_pkg::*;

    // A stalled result must not change under the sink.
    `BSD_ASSERT(a_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_pixel_argb), "result changed while stalled")

    `BSD_ASSERT(a_kind, i_out_valid |-> (i_kind == KIND_PIXEL || i_kind == KIND_ACCEPT || i_kind == KIND_REJECT), "undefined result kind")

    `BSD_ASSERT(a_pixel, i_out_valid && i_kind == KIND_PIXEL |-> i_error_code == ERR_NONE && i_image_width == '0 && i_image_height == '0, "pixel carries header fields")

    // An accepted header always has non-zero dimensions and no pixel data.
    `BSD_ASSERT(a_accept, i_out_valid && i_kind == KIND_ACCEPT |-> i_image_width != '0 && i_image_height != '0 && i_pixel_argb == '0 && !i_last_pixel, "malformed header acceptance")

    `BSD_ASSERT(a_reject, i_out_valid && i_kind == KIND_REJECT |-> i_error_code <= ERR_COMPR && !i_last_pixel && i_image_width == '0, "malformed header rejection")
endmodule

bind bmp_stream_decoder_core bsd_checker u_bsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.kind),
    .i_error_code   (o_out.error_code),
    .i_pixel_argb   (o_out.pixel_argb),
    .i_image_width  (o_out.image_width),
    .i_image_height (o_out.image_height),
    .i_last_pixel   (o_out.last_pixel)
);
